// File: rtl/core/asr_pkg.sv
package asr_pkg;

	localparam int DEF_MAX_ITEMS = 64;
	localparam int W_DIM         = 16;
	localparam int W_AREA        = 2 * W_DIM;
	localparam int W_POS         = 6;

	// One stored rectangle; its position in the set is its store address.
	typedef struct packed {
		logic [W_DIM-1:0]  width;
		logic [W_DIM-1:0]  height;
		logic [W_AREA-1:0] area;
	} rect_entry_t;

	// Control from the sequencer to the selection unit.
	typedef struct packed {
		logic start_set;   // first scan of a set: every entry qualifies
		logic clear_best;  // drop the running best before a scan
		logic advance;     // best becomes the bound for the next scan
	} asr_sel_ctl_t;

	function automatic logic [W_AREA-1:0] area_of(input logic [W_DIM-1:0] w,
			input logic [W_DIM-1:0] h);
		area_of = W_AREA'(w) * W_AREA'(h);
	endfunction

endpackage

// File: rtl/core/asr_if.sv
interface asr_item_if import asr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [W_DIM-1:0] item_width;
	logic [W_DIM-1:0] item_height;
	logic             set_end;

	modport source(output valid, item_width, item_height, set_end, input ready);
	modport sink(input valid, item_width, item_height, set_end, output ready);
endinterface

interface asr_result_if import asr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [W_DIM-1:0] out_width;
	logic [W_DIM-1:0] out_height;
	logic [W_POS-1:0] original_position;
	logic             run_end;
	logic             dropped_items;

	modport source(output valid, out_width, out_height, original_position, run_end,
		dropped_items, input ready);
	modport sink(input valid, out_width, out_height, original_position, run_end,
		dropped_items, output ready);
endinterface

// File: rtl/core/asr_store.sv
module asr_store import asr_pkg::*; #(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS,
	localparam int AW = $clog2(MAX_ITEMS)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  rect_entry_t   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output rect_entry_t   rd_data
);

	rect_entry_t mem [MAX_ITEMS];
	rect_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/asr_select.sv
module asr_select import asr_pkg::*; #(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS,
	localparam int AW = $clog2(MAX_ITEMS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  asr_sel_ctl_t  ctl,
	input  logic          cand_vld,
	input  logic [AW-1:0] cand_idx,
	input  rect_entry_t   cand,
	output rect_entry_t   best,
	output logic [AW-1:0] best_idx,
	output logic          best_have
);

	rect_entry_t       best_q;
	logic [AW-1:0]     best_idx_q;
	logic              have_q;
	logic              first_q;
	logic [W_AREA-1:0] prev_area_q;
	logic [AW-1:0]     prev_idx_q;
	logic              qual;
	logic              better;

	// Order is area descending, then index ascending; a candidate must come
	// strictly after the previously emitted entry.
	assign qual = first_q || (cand.area < prev_area_q) ||
		((cand.area == prev_area_q) && (cand_idx > prev_idx_q));
	// Scan runs in ascending index, so ties keep the earlier entry.
	assign better = !have_q || (cand.area > best_q.area);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			first_q <= 1'b0;
		end else begin
			if (ctl.start_set) begin
				first_q <= 1'b1;
			end else if (ctl.advance) begin
				first_q <= 1'b0;
			end
			if (ctl.clear_best) begin
				have_q <= 1'b0;
			end else if (cand_vld && qual && better) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear_best && cand_vld && qual && better) begin
			best_q     <= cand;
			best_idx_q <= cand_idx;
		end
		if (ctl.advance) begin
			prev_area_q <= best_q.area;
			prev_idx_q  <= best_idx_q;
		end
	end

	assign best      = best_q;
	assign best_idx  = best_idx_q;
	assign best_have = have_q;

endmodule

// File: rtl/core/area_descending_sorter_top.sv
// Channel   Dir  Payload                                               Beat
// items     in   item_width, item_height, set_end                      one rectangle
// results   out  out_width, out_height, original_position, run_end,    one sorted rectangle
//                dropped_items
//
// Cycles: items are taken one per cycle while collecting. After the beat with
// set_end the block stops taking items and emits n results; each result costs
// one scan of the store (n reads through its single read port), then the last
// registered read, then the load into the output register.
// Reset clears all control state; the store itself holds no reset value.
// A stall on results holds the output register and pauses the next emit only.
module area_descending_sorter_top import asr_pkg::*; #(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input logic        clk,
	input logic        arst_n,
	asr_item_if.sink   items,
	asr_result_if.source results
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;     // rectangles stored in this set
	logic [CW-1:0] n_q;         // run length, latched at set_end
	logic          ovf_q;       // an item of this set was dropped
	logic [AW-1:0] rd_addr_q;   // scan read pointer
	logic          issue_q;     // scan still issuing reads
	logic [CW-1:0] rank_q;      // results emitted so far in this run
	logic          out_vld_q;
	logic          vld_s1;
	logic          last_s1;
	logic [AW-1:0] idx_s1;

	logic          in_take;
	logic          full;
	logic          wr_en;
	rect_entry_t   wr_data;
	logic          rd_en;
	logic          issue_last;
	logic          out_free;
	logic          load;
	logic          run_end_nxt;
	rect_entry_t   rd_data;
	rect_entry_t   best;
	logic [AW-1:0] best_idx;
	logic          best_have;
	asr_sel_ctl_t  sel_ctl;

	logic [W_DIM-1:0] out_width_q;
	logic [W_DIM-1:0] out_height_q;
	logic [W_POS-1:0] out_pos_q;
	logic             out_run_end_q;
	logic             out_dropped_q;

	// Collect side
	assign items.ready = (state_q == ST_COLLECT);
	assign in_take     = items.valid && items.ready;
	assign full        = (count_q == CW'(MAX_ITEMS));
	assign wr_en       = in_take && !full;
	assign wr_data     = '{width:  items.item_width,
		height: items.item_height,
		area:   area_of(items.item_width, items.item_height)};

	// Scan side: one read a beat, data back in the next cycle
	assign rd_en       = (state_q == ST_SCAN) && issue_q;
	assign issue_last  = (CW'(rd_addr_q) == (n_q - CW'(1)));
	assign out_free    = !out_vld_q || results.ready;
	assign load        = (state_q == ST_EMIT) && out_free;
	assign run_end_nxt = (rank_q == (n_q - CW'(1)));

	assign sel_ctl.start_set  = in_take && items.set_end;
	assign sel_ctl.clear_best = (in_take && items.set_end) || load;
	assign sel_ctl.advance    = load;

	asr_store #(.MAX_ITEMS(MAX_ITEMS)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(count_q)),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	asr_select #(.MAX_ITEMS(MAX_ITEMS)) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sel_ctl),
		.cand_vld  (vld_s1),
		.cand_idx  (idx_s1),
		.cand      (rd_data),
		.best      (best),
		.best_idx  (best_idx),
		.best_have (best_have)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			count_q   <= '0;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			rd_addr_q <= '0;
			issue_q   <= 1'b0;
			rank_q    <= '0;
			out_vld_q <= 1'b0;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			idx_s1    <= '0;
		end else begin
			vld_s1  <= rd_en;
			last_s1 <= rd_en && issue_last;
			idx_s1  <= rd_addr_q;

			if (load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_COLLECT: begin
					if (in_take) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (items.set_end) begin
							n_q       <= full ? count_q : count_q + CW'(1);
							rd_addr_q <= '0;
							issue_q   <= 1'b1;
							rank_q    <= '0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						if (issue_last) begin
							issue_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + AW'(1);
						end
					end
					// best is final in the cycle after the last candidate
					if (vld_s1 && last_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						rank_q <= rank_q + CW'(1);
						if (run_end_nxt) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_COLLECT;
						end else begin
							rd_addr_q <= '0;
							issue_q   <= 1'b1;
							state_q   <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_width_q   <= best.width;
			out_height_q  <= best.height;
			out_pos_q     <= W_POS'(best_idx);
			out_run_end_q <= run_end_nxt;
			out_dropped_q <= ovf_q;
		end
	end

	assign results.valid             = out_vld_q;
	assign results.out_width         = out_width_q;
	assign results.out_height        = out_height_q;
	assign results.original_position = out_pos_q;
	assign results.run_end           = out_run_end_q;
	assign results.dropped_items     = out_dropped_q;

`ifndef NO_ASSERTIONS
	// A finished scan always has found an entry to emit.
	a_emit_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> best_have)
		else $error("emit without a selected entry");

	// Reads never go past the stored run.
	a_read_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (CW'(idx_s1) < n_q))
		else $error("scan read beyond stored run");

	// Emitted count stays below the run length while the run is active.
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> (rank_q < n_q))
		else $error("rank past run length");

	// The last beat of a run returns the block to an empty set.
	a_run_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(load && run_end_nxt) |=> (state_q == ST_COLLECT && count_q == '0 && !ovf_q))
		else $error("set not cleared after run end");
`endif

endmodule

// File: tb/asr_tb_pkg.sv
package asr_tb_pkg;
	import asr_pkg::*;

	typedef struct packed {
		logic [W_DIM-1:0] width;
		logic [W_DIM-1:0] height;
		logic [W_POS-1:0] position;
		logic             run_end;
		logic             dropped;
	} sorted_rect_t;

	// Collects the rectangles of the current set and, on set end, queues
	// them in the order the block must emit them.
	class sorted_rect_board;
		logic [W_DIM-1:0] set_w[$];
		logic [W_DIM-1:0] set_h[$];
		bit               set_overflow;
		sorted_rect_t     expected_rects[$];
		int unsigned      fail_count;

		function void note_rect(input logic [W_DIM-1:0] w, input logic [W_DIM-1:0] h,
				input logic last);
			logic [W_AREA-1:0] area[DEF_MAX_ITEMS];
			int                order[DEF_MAX_ITEMS];
			int                n;
			int                j;
			sorted_rect_t      r;
			if (set_w.size() < DEF_MAX_ITEMS) begin
				set_w.push_back(w);
				set_h.push_back(h);
			end else begin
				set_overflow = 1'b1;
			end
			if (!last)
				return;
			n = set_w.size();
			for (int i = 0; i < n; i++)
				area[i] = {{W_DIM{1'b0}}, set_w[i]} * {{W_DIM{1'b0}}, set_h[i]};
			// stable insertion sort, largest area first
			for (int i = 0; i < n; i++) begin
				j = i;
				while (j > 0 && area[order[j-1]] < area[i]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = i;
			end
			for (int i = 0; i < n; i++) begin
				r.width    = set_w[order[i]];
				r.height   = set_h[order[i]];
				r.position = W_POS'(order[i]);
				r.run_end  = (i == n - 1);
				r.dropped  = set_overflow;
				expected_rects.push_back(r);
			end
			set_w = {};
			set_h = {};
			set_overflow = 1'b0;
		endfunction

		function void compare_field(input string name, input longint unsigned exp_v,
				input longint unsigned act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
				fail_count++;
			end
		endfunction

		function void check_rect(input sorted_rect_t got);
			sorted_rect_t exp_r;
			if (expected_rects.size() == 0) begin
				$display("%0t: unexpected result expected none actual w=%0d h=%0d pos=%0d",
					$time, got.width, got.height, got.position);
				fail_count++;
				return;
			end
			exp_r = expected_rects.pop_front();
			compare_field("out_width", exp_r.width, got.width);
			compare_field("out_height", exp_r.height, got.height);
			compare_field("original_position", exp_r.position, got.position);
			compare_field("run_end", exp_r.run_end, got.run_end);
			compare_field("dropped_items", exp_r.dropped, got.dropped);
		endfunction

		function int pending();
			return expected_rects.size();
		endfunction
	endclass

endpackage

// File: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import asr_pkg::*;
	import asr_tb_pkg::*;

	// The watchdog limit covers the whole run, largest sets and stalls included, many times over.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 255;
	localparam int DRAIN_CYCLES  = 100;

	logic clk = 1'b0;
	logic arst_n;

	asr_item_if   items();
	asr_result_if results();

	area_descending_sorter_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results)
	);

	always #5 clk = ~clk;

	sorted_rect_board board = new();

	// Percent of cycles in which each side holds back; dropped to zero for
	// a stretch of sets so the block also sees back-to-back traffic.
	int idle_pct = 30;
	int unsigned cycles = 0;

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side back-pressure: ready drops at random, held low in reset.
	always @(posedge clk) begin
		results.ready <= arst_n && ($urandom_range(99) >= idle_pct);
	end

	// Result monitor: values read at the edge are the pre-edge values.
	always @(posedge clk) begin
		sorted_rect_t got;
		if (arst_n && results.valid && results.ready) begin
			got.width    = results.out_width;
			got.height   = results.out_height;
			got.position = results.original_position;
			got.run_end  = results.run_end;
			got.dropped  = results.dropped_items;
			board.check_rect(got);
		end
	end

	// One rectangle beat. Valid is left high after acceptance; the next
	// call lowers it only if it idles, so valid never gets two updates in
	// one step.
	task automatic send_rect(input logic [W_DIM-1:0] w, input logic [W_DIM-1:0] h,
			input logic last);
		while ($urandom_range(99) < idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid       <= 1'b1;
		items.item_width  <= w;
		items.item_height <= h;
		items.set_end     <= last;
		do
			@(posedge clk);
		while (!items.ready);
		board.note_rect(w, h, last);
	endtask

	// Dimension mix: zeros, full scale, tiny values for area ties, single
	// bits, and the full range.
	function automatic logic [W_DIM-1:0] pick_dim();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return W_DIM'($urandom_range(1, 3));
			4:       return W_DIM'(1) << $urandom_range(W_DIM - 1);
			default: return W_DIM'($urandom_range(65535));
		endcase
	endfunction

	initial begin
		int sent;
		int set_no;
		int set_len;

		arst_n            = 1'b0;
		items.valid       = 1'b0;
		items.item_width  = '0;
		items.item_height = '0;
		items.set_end     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Largest possible area, alone in its set.
		send_rect('1, '1, 1'b1);

		// All-zero areas (zero width or height) must keep arrival order.
		send_rect(16'd0, 16'd5, 1'b0);
		send_rect(16'd3, 16'd0, 1'b0);
		send_rect(16'd0, 16'd0, 1'b1);

		// Equal-area pairs in two shapes each, a near tie, full-scale and zero mixed in.
		send_rect('1, 16'd1, 1'b0);
		send_rect(16'd1, '1, 1'b0);
		send_rect(16'd256, 16'd256, 1'b0);
		send_rect(16'd2, 16'd3, 1'b0);
		send_rect('1, '1, 1'b0);
		send_rect(16'd0, '1, 1'b0);
		send_rect(16'd6, 16'd1, 1'b1);

		// Ascending arrival: the run comes out fully reversed.
		send_rect(16'd1, 16'd1, 1'b0);
		send_rect(16'd2, 16'd2, 1'b0);
		send_rect(16'd3, 16'd3, 1'b0);
		send_rect(16'd4, 16'd4, 1'b1);

		// Random sets. Set 4 fills the store exactly; set 9 overruns it so
		// the final, dropped beat still carries set end. The rest stay small.
		sent   = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			if (set_no == 4)
				set_len = DEF_MAX_ITEMS;
			else if (set_no == 9)
				set_len = DEF_MAX_ITEMS + 3;
			else
				set_len = $urandom_range(1, 8);
			idle_pct = (set_no >= 12 && set_no < 18) ? 0 : 30;
			for (int i = 0; i < set_len; i++)
				send_rect(pick_dim(), pick_dim(), i == set_len - 1);
			sent += set_len;
			set_no++;
		end
		items.valid <= 1'b0;
		idle_pct = 30;

		// Drain, then watch a little longer for stray beats.
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/asr_pkg.sv
rtl/core/asr_if.sv
rtl/core/asr_store.sv
rtl/core/asr_select.sv
rtl/core/area_descending_sorter_top.sv
tb/asr_tb_pkg.sv
tb/tb_top.sv
